// ===== design/tcw_pkg.sv =====
// shared types, constants and control structs for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLS     = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLS * ROWS;
  localparam int COL_W    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int CURSOR_W = 11;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  BLANK_CODE   = 8'h20;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;
  localparam logic [15:0] RESET_CELL   = {ATTR_RESET, BLANK_CODE};

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_ATTRIBUTE = 0;

  typedef enum logic [1:0] {
    ACT_PRINT      = 2'd0,
    ACT_SET_CURSOR = 2'd1,
    ACT_CLEAR      = 2'd2,
    ACT_READ       = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  character;
    logic        use_position;
    logic [6:0]  column;
    logic [4:0]  line;
  } request_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [7:0]          read_char;
    logic                scrolled;
  } result_t;

  typedef enum logic [1:0] {
    SWEEP_HOLD,
    SWEEP_CLEAR,
    SWEEP_STEP
  } sweep_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_COPY,
    WR_BLANK,
    WR_RESET
  } wr_sel_t;

  typedef struct packed {
    logic      accept;
    logic      exec;
    logic      read_sweep;
    logic      load_result;
    sweep_op_t sweep_op;
    wr_sel_t   wr_sel;
  } dp_ctl_t;

  typedef struct packed {
    action_t action;
    logic    scroll_needed;
    logic    sweep_last;
    logic    scroll_last;
    logic    out_free;
  } dp_status_t;

endpackage

// ===== design/tcw_ctrl.sv =====
// sequencing state machine for the text console writer
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  tcw_pkg::dp_status_t sts,
  output tcw_pkg::dp_ctl_t    ctl
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign request_stall = (state != ST_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.sweep_op = SWEEP_HOLD;
    ctl.wr_sel   = WR_NONE;
    state_next = state;
    unique case (state)
      ST_INIT: begin
        ctl.wr_sel   = WR_RESET;
        ctl.sweep_op = SWEEP_STEP;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (request_valid) begin
          ctl.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        unique case (sts.action)
          ACT_PRINT: begin
            ctl.wr_sel = WR_CHAR;
            if (sts.scroll_needed) begin
              ctl.sweep_op = SWEEP_CLEAR;
              state_next   = ST_SCROLL;
            end else if (sts.out_free) begin
              ctl.load_result = 1'b1;
              state_next      = ST_IDLE;
            end else begin
              state_next = ST_DONE;
            end
          end
          ACT_SET_CURSOR: begin
            if (sts.out_free) begin
              ctl.load_result = 1'b1;
              state_next      = ST_IDLE;
            end else begin
              state_next = ST_DONE;
            end
          end
          ACT_CLEAR: begin
            ctl.sweep_op = SWEEP_CLEAR;
            state_next   = ST_FILL;
          end
          ACT_READ: begin
            // read data comes back registered, pick it up in done
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SCROLL: begin
        ctl.read_sweep = 1'b1;
        ctl.wr_sel     = WR_COPY;
        if (sts.scroll_last) begin
          ctl.sweep_op = SWEEP_HOLD;
          state_next   = ST_FILL;
        end else begin
          ctl.sweep_op = SWEEP_STEP;
        end
      end
      ST_FILL: begin
        ctl.wr_sel   = WR_BLANK;
        ctl.sweep_op = SWEEP_STEP;
        if (sts.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/tcw_datapath.sv =====
// cell store, cursor, sweep counter and result register
`timescale 1ns / 1ps

module tcw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::request_t   request,
  input  logic [7:0]          attribute,
  input  tcw_pkg::dp_ctl_t    ctl,
  output tcw_pkg::dp_status_t sts,
  output logic                result_valid,
  input  logic                result_stall,
  output tcw_pkg::result_t    result
);
  import tcw_pkg::*;

  logic [15:0] cells [CELLS];
  logic [15:0] rdata;
  logic        we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;

  request_t          req_q;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col_next;
  logic [ROW_W-1:0]  cur_row_next;
  logic [CNT_W-1:0]  cnt;
  logic              scrolled;

  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  sel_col;
  logic [ROW_W-1:0]  sel_row;
  logic [ADDR_W-1:0] tgt_addr;
  logic [ADDR_W-1:0] sel_addr;
  logic [ADDR_W-1:0] cnt_addr;
  logic [ADDR_W-1:0] copy_raddr;
  logic [ADDR_W-1:0] cursor_idx;
  logic [COL_W-1:0]  print_col;
  logic [ROW_W-1:0]  print_row;
  logic              is_newline;
  logic              wrap;
  logic              last_row;

  // clamp requested position onto the screen
  assign tgt_col = (int'(req_q.column) >= COLS) ? COL_W'(COLS - 1) : COL_W'(req_q.column);
  assign tgt_row = (int'(req_q.line) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(req_q.line);
  assign sel_col = req_q.use_position ? tgt_col : cur_col;
  assign sel_row = req_q.use_position ? tgt_row : cur_row;

  assign tgt_addr = ADDR_W'(int'(tgt_row) * COLS + int'(tgt_col));
  assign sel_addr = ADDR_W'(int'(sel_row) * COLS + int'(sel_col));

  assign is_newline = (req_q.character == NEWLINE_CODE);
  assign wrap       = is_newline || (sel_col == COL_W'(COLS - 1));
  assign last_row   = (sel_row == ROW_W'(ROWS - 1));
  assign print_col  = wrap ? '0 : sel_col + 1'b1;
  assign print_row  = (wrap && !last_row) ? sel_row + 1'b1 : sel_row;

  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    if (ctl.exec) begin
      unique case (req_q.action)
        ACT_PRINT: begin
          cur_col_next = print_col;
          cur_row_next = print_row;
        end
        ACT_SET_CURSOR: begin
          cur_col_next = tgt_col;
          cur_row_next = tgt_row;
        end
        ACT_CLEAR: begin
          cur_col_next = '0;
          cur_row_next = '0;
        end
        ACT_READ: begin
          cur_col_next = cur_col;
          cur_row_next = cur_row;
        end
      endcase
    end
  end

  assign cursor_idx = ADDR_W'(int'(cur_row_next) * COLS + int'(cur_col_next));

  // sweep addressing for clear, blank fill and row copy
  assign cnt_addr   = cnt[ADDR_W-1:0];
  assign copy_raddr = ADDR_W'(int'(cnt) + COLS);
  assign raddr      = ctl.read_sweep ? copy_raddr : tgt_addr;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_addr;
    wdata = RESET_CELL;
    unique case (ctl.wr_sel)
      WR_NONE: begin
        we = 1'b0;
      end
      WR_CHAR: begin
        we    = !is_newline;
        waddr = sel_addr;
        wdata = {attribute, req_q.character};
      end
      WR_COPY: begin
        // write uses the registered read data, so it trails the read into the next cycle
        we    = (cnt != '0);
        waddr = cnt_addr - 1'b1;
        wdata = rdata;
      end
      WR_BLANK: begin
        we    = 1'b1;
        wdata = {attribute, BLANK_CODE};
      end
      WR_RESET: begin
        we    = 1'b1;
        wdata = RESET_CELL;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    rdata <= cells[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_q <= request;
    end
    if (ctl.load_result) begin
      result.cursor    <= CURSOR_W'(cursor_idx);
      result.read_char <= (req_q.action == ACT_READ) ? rdata[7:0] : 8'd0;
      result.scrolled  <= scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col      <= '0;
      cur_row      <= '0;
      cnt          <= '0;
      scrolled     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      unique case (ctl.sweep_op)
        SWEEP_HOLD:  cnt <= cnt;
        SWEEP_CLEAR: cnt <= '0;
        SWEEP_STEP:  cnt <= cnt + 1'b1;
        default:     cnt <= cnt;
      endcase
      if (ctl.accept) begin
        scrolled <= 1'b0;
      end else if (ctl.exec && sts.scroll_needed) begin
        scrolled <= 1'b1;
      end
      if (ctl.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.action        = req_q.action;
  assign sts.scroll_needed = (req_q.action == ACT_PRINT) && wrap && last_row;
  assign sts.sweep_last    = (cnt == CNT_W'(CELLS - 1));
  assign sts.scroll_last   = (cnt == CNT_W'(CELLS - COLS));
  assign sts.out_free      = !result_valid || !result_stall;

endmodule

// ===== design/text_console_writer.sv =====
// text console writer top level: register port, controller and datapath
// print and set-cursor requests pass through the exec state to the registered result, a read also through done
// a print that scrolls runs a row copy and then a blank fill: these walk the
// cell store one cell per cycle over its single write port; clear screen runs a blank fill
// one request in work at a time: a new request is taken only once the controller is back in idle
// after reset a clearing pass fills every cell of the store, requests stall meanwhile
`timescale 1ns / 1ps

module text_console_writer (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  // request channel
  input  logic                                request_valid,
  output logic                                request_stall,
  input  tcw_pkg::request_t                   request,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output tcw_pkg::result_t                    result
);
  import tcw_pkg::*;

  logic       attr_hit;
  logic [7:0] attribute;

  dp_ctl_t    ctl;
  dp_status_t sts;

  // single register, word index taken from the upper address bit
  assign attr_hit = (int'(paddr[CFG_ADDR_W-1:2]) == REG_ATTRIBUTE);

  // no wait states on the register port
  assign pready = 1'b1;
  assign prdata = attr_hit ? CFG_DATA_W'(attribute) : '0;

  // attribute register, stored with every written or blanked cell
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && attr_hit) begin
      attribute <= pwdata[7:0];
    end
  end

  // sequencing: reset clearing pass, request execution, row copy and fills
  tcw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .sts           (sts),
    .ctl           (ctl)
  );

  // cell store, cursor and result register
  tcw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .attribute    (attribute),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== verif/tb_text_console_writer.sv =====
// testbench for the text console writer: cell store predictor, request driver, result monitor
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  // rounds of no progress before the run is abandoned; a scroll or clear walks
  // the whole store, the clearing pass after reset does too, plus receiver stalls
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASE_REQUESTS = 135;
  localparam int RANDOM_PHASES  = 8;
  localparam logic [CFG_ADDR_W-1:0] ATTRIBUTE_ADDR = CFG_ADDR_W'(4 * REG_ATTRIBUTE);

  // keeps its own copy of the cell store, cursor and attribute, and queues the
  // result that each accepted request should produce
  class console_scoreboard;
    logic [15:0] screen_copy [CELLS];
    int          cursor_pos;
    logic [7:0]  attribute;
    result_t     expected_results [$];
    int          errors;

    function new();
      for (int i = 0; i < CELLS; i++) screen_copy[i] = RESET_CELL;
      cursor_pos = 0;
      attribute  = ATTR_RESET;
      errors     = 0;
    endfunction

    function void set_attribute(logic [CFG_DATA_W-1:0] value);
      attribute = value[7:0];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // out-of-range column or line is pinned to the last one
    function int cell_index(logic [6:0] column, logic [4:0] line);
      int c;
      int r;
      c = (column >= COLS) ? COLS - 1 : int'(column);
      r = (line >= ROWS) ? ROWS - 1 : int'(line);
      return r * COLS + c;
    endfunction

    function void note_request(request_t req);
      result_t exp;
      int      pos;
      exp = '0;
      case (req.action)
        ACT_PRINT: begin
          pos = req.use_position ? cell_index(req.column, req.line) : cursor_pos;
          if (pos >= CELLS) pos = CELLS - 1;
          if (req.character == NEWLINE_CODE) begin
            pos = (pos / COLS + 1) * COLS;
          end else begin
            screen_copy[pos] = {attribute, req.character};
            pos++;
          end
          // ran past the last cell: rows move up, bottom row goes blank
          if (pos >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_copy[i] = screen_copy[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_copy[i] = {attribute, BLANK_CODE};
            pos -= COLS;
            exp.scrolled = 1'b1;
          end
          cursor_pos = pos;
        end
        ACT_SET_CURSOR: begin
          cursor_pos = cell_index(req.column, req.line);
        end
        ACT_CLEAR: begin
          for (int i = 0; i < CELLS; i++) screen_copy[i] = {attribute, BLANK_CODE};
          cursor_pos = 0;
        end
        default: begin
          exp.read_char = screen_copy[cell_index(req.column, req.line)][7:0];
        end
      endcase
      exp.cursor = CURSOR_W'(cursor_pos);
      expected_results.push_back(exp);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", got));
      end else begin
        exp = expected_results.pop_front();
        if (got.cursor !== exp.cursor)
          report_mismatch($sformatf("cursor %0d, expected %0d", got.cursor, exp.cursor));
        if (got.read_char !== exp.read_char)
          report_mismatch($sformatf("read_char %0h, expected %0h",
                                    got.read_char, exp.read_char));
        if (got.scrolled !== exp.scrolled)
          report_mismatch($sformatf("scrolled %0b, expected %0b", got.scrolled, exp.scrolled));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  request_valid;
  logic                  request_stall;
  request_t              request;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;

  console_scoreboard sb = new();

  // percent chance per cycle of a sender gap and of a receiver stall
  int send_idle_pct;
  int stall_pct;
  int phase_sent;
  int quiet_cycles;

  text_console_writer dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver side: stall decided at each falling edge
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // results are taken at the rising edge they are accepted on
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // no request or result accepted for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("** text_console_writer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register write in setup and access cycles, then read back the attribute
  task automatic write_attribute(logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTRIBUTE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_attribute(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value[7:0])
      sb.report_mismatch($sformatf("attribute reads %0h, written %0h", prdata[7:0], value[7:0]));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold the request until accepted; random gaps with valid low before it
  task automatic send_request(request_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      request_valid <= 1'b0;
      @(negedge clk);
    end
    request_valid <= 1'b1;
    request       <= req;
    do @(posedge clk); while (request_stall);
    sb.note_request(req);
    phase_sent++;
  endtask

  task automatic stop_requests();
    @(negedge clk);
    request_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic request_t make_request(action_t action, logic [7:0] character,
                                            logic use_position, logic [6:0] column,
                                            logic [4:0] line);
    request_t req;
    req.action       = action;
    req.character    = character;
    req.use_position = use_position;
    req.column       = column;
    req.line         = line;
    return req;
  endfunction

  function automatic request_t random_request();
    return make_request(action_t'($urandom_range(3)), 8'($urandom_range(255)),
                        1'($urandom_range(1)), 7'($urandom_range(127)),
                        5'($urandom_range(31)));
  endfunction

  // one random burst: mostly text runs at the cursor, some of them on the
  // bottom row so that runs and newlines push the screen up
  task automatic send_burst();
    request_t req;
    int       kind;
    kind = $urandom_range(99);
    if (kind < 55) begin
      if ($urandom_range(1)) begin
        req = random_request();
        req.action = ACT_SET_CURSOR;
        if ($urandom_range(9) < 4) req.line = 5'(ROWS - 1);
        send_request(req);
      end
      repeat ($urandom_range(12, 3)) begin
        req = random_request();
        req.action       = ACT_PRINT;
        req.use_position = 1'b0;
        if ($urandom_range(99) < 12) req.character = NEWLINE_CODE;
        send_request(req);
      end
    end else if (kind < 72) begin
      req = random_request();
      req.action       = ACT_PRINT;
      req.use_position = 1'b1;
      if ($urandom_range(99) < 10) req.character = NEWLINE_CODE;
      send_request(req);
    end else if (kind < 90) begin
      repeat ($urandom_range(4, 1)) begin
        req = random_request();
        req.action = ACT_READ;
        send_request(req);
      end
    end else if (kind < 93) begin
      req = random_request();
      req.action = ACT_CLEAR;
      send_request(req);
    end else begin
      // noise: anything the fields allow
      repeat ($urandom_range(3, 1)) send_request(random_request());
    end
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    request_valid = 1'b0;
    request       = '0;
    result_stall  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    phase_sent    = 0;
    quiet_cycles  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // attribute at its low extreme, upper data bits set to show they are dropped
    write_attribute({24'hA5C3F0, 8'h00});

    // directed part, no idling
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd0, 5'd0));       // blank after reset
    send_request(make_request(ACT_READ, 8'hFF, 1'b1, 7'd127, 5'd31));    // pinned to last cell
    send_request(make_request(ACT_PRINT, 8'h00, 1'b0, 7'd127, 5'd31));   // character zero at cursor
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd0, 5'd0));
    // print into the last cell by position: screen moves up
    send_request(make_request(ACT_PRINT, 8'hFF, 1'b1, 7'd79, 5'd24));
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd79, 5'd23));
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd0, 5'd24));
    // cursor pinned past the end, then a print there scrolls
    send_request(make_request(ACT_SET_CURSOR, 8'h00, 1'b0, 7'd127, 5'd31));
    send_request(make_request(ACT_PRINT, 8'h41, 1'b0, 7'd0, 5'd0));
    // newline on the bottom row
    send_request(make_request(ACT_SET_CURSOR, NEWLINE_CODE, 1'b1, 7'd5, 5'd24));
    send_request(make_request(ACT_PRINT, NEWLINE_CODE, 1'b0, 7'd0, 5'd0));
    // newline at a pinned position, then at the cursor
    send_request(make_request(ACT_PRINT, NEWLINE_CODE, 1'b1, 7'd100, 5'd3));
    send_request(make_request(ACT_PRINT, NEWLINE_CODE, 1'b0, 7'd0, 5'd0));
    send_request(make_request(ACT_SET_CURSOR, 8'h00, 1'b0, 7'd0, 5'd0));
    send_request(make_request(ACT_PRINT, 8'h7F, 1'b1, 7'd127, 5'd0));
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd80, 5'd0));
    send_request(make_request(ACT_READ, 8'h55, 1'b1, 7'd0, 5'd23));
    send_request(make_request(ACT_CLEAR, 8'hAA, 1'b1, 7'd42, 5'd17));
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd79, 5'd0));
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd0, 5'd24));
    send_request(make_request(ACT_SET_CURSOR, 8'hFF, 1'b1, 7'd79, 5'd24));
    send_request(make_request(ACT_PRINT, 8'h80, 1'b0, 7'd0, 5'd0));
    send_request(make_request(ACT_READ, 8'h00, 1'b0, 7'd79, 5'd23));
    stop_requests();
    wait_drained();

    // random phases, cycling through the idling patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      if (phase == 0) write_attribute({24'($urandom_range(255)), 8'hFF});
      else write_attribute($urandom());
      phase_sent = 0;
      while (phase_sent < PHASE_REQUESTS) send_burst();
      stop_requests();
      wait_drained();
    end

    // allow a stray late result to show up
    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule
